>>> src/mkm_pkg.sv
package mkm_pkg;

    localparam int DEF_PARTITIONS  = 8;
    localparam int DEF_ROWS        = 256;
    localparam int DEF_KEY_COLUMNS = 4;

    localparam int KEY_W     = 64;
    localparam int MAX_COLS  = 4;
    localparam int PART_W    = 3;
    localparam int ROW_OUT_W = 8;
    localparam int CFG_W     = 8;
    localparam int KCOUNT_W  = 3;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PULL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SPARE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CT_INT32 = 2'd0,
        CT_INT64 = 2'd1,
        CT_FP32  = 2'd2,
        CT_FP64  = 2'd3
    } col_type_t;

    typedef enum logic {
        CFG_KEY_COUNT = 1'b0,
        CFG_TYPES     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic finish;
        logic push;
    } mkm_cmd_t;

    typedef struct packed {
        op_t  op;
        logic scan_done;
        logic out_free;
    } mkm_stat_t;

    function automatic logic [KEY_W-1:0] order_key(input logic [1:0] t,
                                                   input logic [KEY_W-1:0] raw);
        logic [31:0]      v32;
        logic [KEY_W-1:0] v64;
        logic [KEY_W-1:0] res;
        v32 = raw[31:0];
        v64 = raw;
        unique case (col_type_t'(t))
            CT_INT32: res = {32'd0, v32 ^ 32'h8000_0000};
            CT_INT64: res = v64 ^ 64'h8000_0000_0000_0000;
            CT_FP32:
            begin
                if (v32 == 32'h8000_0000)
                    v32 = 32'd0;
                res = {32'd0, v32[31] ? ~v32 : (v32 | 32'h8000_0000)};
            end
            default:
            begin
                if (v64 == 64'h8000_0000_0000_0000)
                    v64 = '0;
                res = v64[63] ? ~v64 : (v64 | 64'h8000_0000_0000_0000);
            end
        endcase
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] typed_bits(input logic [1:0] t,
                                                    input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        if (col_type_t'(t) == CT_INT32 || col_type_t'(t) == CT_FP32)
            res = {32'd0, raw[31:0]};
        else
            res = raw;
        return res;
    endfunction

endpackage

>>> src/mkm_in_if.sv
interface mkm_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [mkm_pkg::PART_W-1:0]    partition;
    logic [mkm_pkg::KEY_W-1:0]     key_0;
    logic [mkm_pkg::KEY_W-1:0]     key_1;
    logic [mkm_pkg::KEY_W-1:0]     key_2;
    logic [mkm_pkg::KEY_W-1:0]     key_3;

    modport source (output valid, operation, partition, key_0, key_1, key_2, key_3,
                    input ready);
    modport sink (input valid, operation, partition, key_0, key_1, key_2, key_3,
                  output ready);
endinterface

>>> src/mkm_out_if.sv
interface mkm_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [mkm_pkg::PART_W-1:0]       source_partition;
    logic [mkm_pkg::ROW_OUT_W-1:0]    source_row;
    logic [mkm_pkg::KEY_W-1:0]        out_key_0;
    logic [mkm_pkg::KEY_W-1:0]        out_key_1;
    logic [mkm_pkg::KEY_W-1:0]        out_key_2;
    logic [mkm_pkg::KEY_W-1:0]        out_key_3;
    logic                             last;

    modport source (output valid, status, source_partition, source_row,
                    out_key_0, out_key_1, out_key_2, out_key_3, last,
                    input ready);
    modport sink (input valid, status, source_partition, source_row,
                  out_key_0, out_key_1, out_key_2, out_key_3, last,
                  output ready);
endinterface

>>> src/mkm_ram.sv
module mkm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> src/mkm_ctrl.sv
module mkm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mkm_pkg::mkm_stat_t st,
    output mkm_pkg::mkm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH,
        S_PUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid & ready_reg;
                if (in_valid & ready_reg)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec       = 1'b1;
                cmd.scan_start = (st.op == mkm_pkg::OP_PULL);
                state_next     = (st.op == mkm_pkg::OP_PULL) ? S_SCAN : S_PUT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                cmd.push = st.out_free;
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_put_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT && !st.out_free) |=> state_reg == S_PUT)
        else $error("result left before slot freed");
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && st.scan_done) |=> state_reg == S_FINISH)
        else $error("scan did not finish");
`endif

endmodule

>>> src/mkm_dp.sv
module mkm_dp #(
    parameter int PARTITIONS         = mkm_pkg::DEF_PARTITIONS,
    parameter int ROWS_PER_PARTITION = mkm_pkg::DEF_ROWS,
    parameter int KEY_COLUMNS        = mkm_pkg::DEF_KEY_COLUMNS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [mkm_pkg::CFG_W-1:0]           cfg_data,
    input  logic [1:0]                          in_operation,
    input  logic [mkm_pkg::PART_W-1:0]          in_partition,
    input  logic [mkm_pkg::KEY_W-1:0]           in_key [mkm_pkg::MAX_COLS],
    input  mkm_pkg::mkm_cmd_t                   cmd,
    output mkm_pkg::mkm_stat_t                  st,
    mkm_out_if.source                           out_ch
);

    localparam int DEPTH = PARTITIONS * ROWS_PER_PARTITION;
    localparam int PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int RW    = (ROWS_PER_PARTITION > 1) ? $clog2(ROWS_PER_PARTITION) : 1;
    localparam int CW    = $clog2(ROWS_PER_PARTITION + 1);
    localparam int IW    = $clog2(PARTITIONS + 1);
    localparam int SW    = (IW > mkm_pkg::PART_W) ? IW : mkm_pkg::PART_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int KW    = mkm_pkg::KEY_W;

    logic [mkm_pkg::KCOUNT_W-1:0] kcount_reg;
    logic [mkm_pkg::CFG_W-1:0]    ctypes_reg;

    logic [CW-1:0] fill_reg [PARTITIONS];
    logic [CW-1:0] fill_next [PARTITIONS];
    logic [CW-1:0] head_reg [PARTITIONS];
    logic [CW-1:0] head_next [PARTITIONS];
    logic [TW-1:0] remaining_reg, remaining_next;

    mkm_pkg::op_t               op_reg;
    logic [mkm_pkg::PART_W-1:0] part_reg;
    logic [KW-1:0]              key_reg [KEY_COLUMNS];

    logic [IW-1:0] idx_reg;
    logic          pend_reg;
    logic [PW-1:0] pend_part_reg;
    logic [RW-1:0] pend_row_reg;
    logic          found_reg;
    logic [PW-1:0] best_part_reg;
    logic [RW-1:0] best_row_reg;
    logic [KW-1:0] best_key_reg [KEY_COLUMNS];
    logic [KW-1:0] rdata [KEY_COLUMNS];

    logic [1:0]                    res_status_reg;
    logic [mkm_pkg::PART_W-1:0]    res_part_reg;
    logic [mkm_pkg::ROW_OUT_W-1:0] res_row_reg;
    logic [KW-1:0]                 res_key_reg [mkm_pkg::MAX_COLS];
    logic                          res_last_reg;

    logic                          out_valid_reg;
    logic [1:0]                    out_status_reg;
    logic [mkm_pkg::PART_W-1:0]    out_part_reg;
    logic [mkm_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic [KW-1:0]                 out_key_reg [mkm_pkg::MAX_COLS];
    logic                          out_last_reg;

    logic [SW-1:0]                 sel;
    logic                          sel_ok;
    logic [PW-1:0]                 sel_idx;
    logic [CW-1:0]                 rd_fill;
    logic [CW-1:0]                 rd_head;
    logic                          load_ok;
    logic                          ram_we;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic                          issue;
    logic                          cand_less;
    logic [mkm_pkg::KCOUNT_W-1:0]  ncols;

    // effective column count
    always_comb
    begin
        ncols = kcount_reg;
        if (ncols == '0)
            ncols = mkm_pkg::KCOUNT_W'(1);
        if (ncols > mkm_pkg::KCOUNT_W'(KEY_COLUMNS))
            ncols = mkm_pkg::KCOUNT_W'(KEY_COLUMNS);
    end

    always_comb
    begin
        priority if (cmd.scan_step)
            sel = SW'(idx_reg);
        else if (cmd.finish)
            sel = SW'(best_part_reg);
        else
            sel = SW'(part_reg);
    end

    assign sel_ok  = (sel < SW'(PARTITIONS));
    assign sel_idx = sel[PW-1:0];
    assign rd_fill = sel_ok ? fill_reg[sel_idx] : '0;
    assign rd_head = sel_ok ? head_reg[sel_idx] : '0;

    assign load_ok = sel_ok && (rd_fill < CW'(ROWS_PER_PARTITION));
    assign ram_we  = cmd.exec && (op_reg == mkm_pkg::OP_LOAD) && load_ok;
    assign waddr   = AW'(sel_idx) * AW'(ROWS_PER_PARTITION) + AW'(rd_fill[RW-1:0]);
    assign raddr   = AW'(sel_idx) * AW'(ROWS_PER_PARTITION) + AW'(rd_head[RW-1:0]);
    assign issue   = cmd.scan_step && sel_ok && (rd_head < rd_fill);

    for (genvar c = 0; c < KEY_COLUMNS; c++)
    begin : g_col
        mkm_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_store (
            .clk   (clk),
            .we    (ram_we),
            .waddr (waddr),
            .wdata (key_reg[c]),
            .raddr (raddr),
            .rdata (rdata[c])
        );
    end

    // lexicographic compare of the fetched head against the current best
    always_comb
    begin
        logic          decided;
        logic [KW-1:0] ka;
        logic [KW-1:0] kb;
        decided   = 1'b0;
        cand_less = 1'b0;
        for (int c = 0; c < KEY_COLUMNS; c++)
        begin
            ka = mkm_pkg::order_key(ctypes_reg[2*c +: 2], rdata[c]);
            kb = mkm_pkg::order_key(ctypes_reg[2*c +: 2], best_key_reg[c]);
            if (!decided && (mkm_pkg::KCOUNT_W'(c) < ncols) && (ka != kb))
            begin
                decided   = 1'b1;
                cand_less = (ka < kb);
            end
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        head_next      = head_reg;
        remaining_next = remaining_reg;
        if (cmd.exec && op_reg == mkm_pkg::OP_LOAD && load_ok)
        begin
            fill_next[sel_idx] = rd_fill + CW'(1);
            remaining_next     = remaining_reg + TW'(1);
        end
        else if (cmd.exec && op_reg == mkm_pkg::OP_CLEAR)
        begin
            for (int p = 0; p < PARTITIONS; p++)
            begin
                fill_next[p] = '0;
                head_next[p] = '0;
            end
            remaining_next = '0;
        end
        else if (cmd.finish && found_reg)
        begin
            head_next[sel_idx] = rd_head + CW'(1);
            remaining_next     = remaining_reg - TW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcount_reg    <= mkm_pkg::KCOUNT_W'(1);
            ctypes_reg    <= '0;
            remaining_reg <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PARTITIONS; p++)
            begin
                fill_reg[p] <= '0;
                head_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (mkm_pkg::cfg_index_t'(cfg_index))
                    mkm_pkg::CFG_KEY_COUNT: kcount_reg <= cfg_data[mkm_pkg::KCOUNT_W-1:0];
                    mkm_pkg::CFG_TYPES:     ctypes_reg <= cfg_data;
                    default:                ctypes_reg <= ctypes_reg;
                endcase
            end
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            remaining_reg <= remaining_next;
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg  <= idx_reg + IW'(1);
                pend_reg <= issue;
                if (pend_reg && (!found_reg || cand_less))
                    found_reg <= 1'b1;
            end
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= mkm_pkg::op_t'(in_operation);
            part_reg <= in_partition;
            for (int c = 0; c < KEY_COLUMNS; c++)
                key_reg[c] <= in_key[c];
        end
        if (cmd.scan_step)
        begin
            pend_part_reg <= sel_idx;
            pend_row_reg  <= rd_head[RW-1:0];
            if (pend_reg && (!found_reg || cand_less))
            begin
                best_part_reg <= pend_part_reg;
                best_row_reg  <= pend_row_reg;
                for (int c = 0; c < KEY_COLUMNS; c++)
                    best_key_reg[c] <= rdata[c];
            end
        end
        if (cmd.exec)
        begin
            res_status_reg <= (op_reg == mkm_pkg::OP_LOAD && !load_ok) ?
                              mkm_pkg::ST_DROP : mkm_pkg::ST_OK;
            res_part_reg   <= '0;
            res_row_reg    <= '0;
            res_last_reg   <= 1'b0;
            for (int c = 0; c < mkm_pkg::MAX_COLS; c++)
                res_key_reg[c] <= '0;
        end
        if (cmd.finish)
        begin
            res_status_reg <= found_reg ? mkm_pkg::ST_OK : mkm_pkg::ST_EMPTY;
            res_part_reg   <= found_reg ? mkm_pkg::PART_W'(best_part_reg) : '0;
            res_row_reg    <= found_reg ? mkm_pkg::ROW_OUT_W'(best_row_reg) : '0;
            res_last_reg   <= found_reg && (remaining_reg == TW'(1));
            for (int c = 0; c < mkm_pkg::MAX_COLS; c++)
                res_key_reg[c] <= '0;
            for (int c = 0; c < KEY_COLUMNS; c++)
                if (found_reg && (mkm_pkg::KCOUNT_W'(c) < ncols))
                    res_key_reg[c] <= mkm_pkg::typed_bits(ctypes_reg[2*c +: 2],
                                                          best_key_reg[c]);
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_part_reg   <= res_part_reg;
            out_row_reg    <= res_row_reg;
            out_last_reg   <= res_last_reg;
            out_key_reg    <= res_key_reg;
        end
    end

    assign st.op        = op_reg;
    assign st.scan_done = (idx_reg == IW'(PARTITIONS));
    assign st.out_free  = !out_valid_reg || out_ch.ready;

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = out_status_reg;
    assign out_ch.source_partition = out_part_reg;
    assign out_ch.source_row       = out_row_reg;
    assign out_ch.out_key_0        = out_key_reg[0];
    assign out_ch.out_key_1        = out_key_reg[1];
    assign out_ch.out_key_2        = out_key_reg[2];
    assign out_ch.out_key_3        = out_key_reg[3];
    assign out_ch.last             = out_last_reg;

`ifndef NO_ASSERTIONS
    a_head_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step || cmd.exec) |-> rd_head <= rd_fill)
        else $error("head passed fill");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> rd_fill < CW'(ROWS_PER_PARTITION))
        else $error("write beyond partition");
    a_found_has_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && found_reg) |-> remaining_reg != '0)
        else $error("row found with none remaining");
    a_rows_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !found_reg) |-> remaining_reg == '0)
        else $error("rows remaining but none found");
`endif

endmodule

>>> src/multi_key_k_way_merge_core.sv
// Merges up to PARTITIONS presorted partitions of rows, each row up to four 64-bit key
// columns, into one ascending sequence. A load word appends a row to a partition. A
// pull word fetches each partition head in turn from the column stores and compares
// it with the best row so far in one lexicographic comparator. One word is in flight
// at a time; its result sits in an output register and the block takes the next word
// once that result is handed over or parked. Write configuration only while idle.
module multi_key_k_way_merge_core #(
    parameter int PARTITIONS         = mkm_pkg::DEF_PARTITIONS,
    parameter int ROWS_PER_PARTITION = mkm_pkg::DEF_ROWS,
    parameter int KEY_COLUMNS        = mkm_pkg::DEF_KEY_COLUMNS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [mkm_pkg::CFG_W-1:0] cfg_data,
    mkm_in_if.sink                    in_ch,
    mkm_out_if.source                 out_ch
);

    mkm_pkg::mkm_cmd_t  cmd;
    mkm_pkg::mkm_stat_t st;
    logic               ready;
    logic [mkm_pkg::KEY_W-1:0] keys [mkm_pkg::MAX_COLS];

    assign in_ch.ready = ready;
    assign keys[0]     = in_ch.key_0;
    assign keys[1]     = in_ch.key_1;
    assign keys[2]     = in_ch.key_2;
    assign keys[3]     = in_ch.key_3;

    mkm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .st       (st),
        .cmd      (cmd)
    );

    mkm_dp #(
        .PARTITIONS         (PARTITIONS),
        .ROWS_PER_PARTITION (ROWS_PER_PARTITION),
        .KEY_COLUMNS        (KEY_COLUMNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_operation (in_ch.operation),
        .in_partition (in_ch.partition),
        .in_key       (keys),
        .cmd          (cmd),
        .st           (st),
        .out_ch       (out_ch)
    );

endmodule

>>> test/merge_checker.sv
module merge_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    mkm_in_if          in_mon,
    mkm_out_if         out_mon,
    output int         fails,
    output int         waiting,
    output int         checked
);
    import mkm_pkg::*;

    localparam int NPART = DEF_PARTITIONS;
    localparam int NROWS = DEF_ROWS;

    typedef struct {
        status_t         status;
        logic [2:0]      src_part;
        logic [7:0]      src_row;
        logic [63:0]     keys [4];
        logic            last;
    } merge_row_t;

    logic [63:0] row_store [MAX_COLS][NPART*NROWS];
    int          fill      [NPART];
    int          head      [NPART];
    logic [2:0]  key_count;
    logic [7:0]  col_types;
    merge_row_t  pending_rows [$];

    function automatic logic [63:0] sort_key(input int c, input logic [63:0] raw);
        logic [31:0] w;
        logic [63:0] d;
        w = raw[31:0];
        d = raw;
        case (col_type_t'(col_types[2*c +: 2]))
            CT_INT32: return {32'd0, w ^ 32'h8000_0000};
            CT_INT64: return d ^ 64'h8000_0000_0000_0000;
            CT_FP32:
            begin
                if (w == 32'h8000_0000)
                    w = '0;
                return {32'd0, w[31] ? ~w : {1'b1, w[30:0]}};
            end
            default:
            begin
                if (d == 64'h8000_0000_0000_0000)
                    d = '0;
                return d[63] ? ~d : {1'b1, d[62:0]};
            end
        endcase
    endfunction

    function automatic int used_cols();
        if (key_count == 0)
            return 1;
        if (key_count > MAX_COLS)
            return MAX_COLS;
        return key_count;
    endfunction

    function automatic bit row_below(input int a, input int b);
        logic [63:0] ka;
        logic [63:0] kb;
        for (int c = 0; c < used_cols(); c++)
        begin
            ka = sort_key(c, row_store[c][a]);
            kb = sort_key(c, row_store[c][b]);
            if (ka != kb)
                return ka < kb;
        end
        return 0;
    endfunction

    function automatic merge_row_t merge_step(input op_t op, input logic [2:0] part,
                                              input logic [63:0] k [4]);
        merge_row_t r;
        int         best;
        int         addr;
        int         best_addr;
        logic [1:0] t;
        r.status   = ST_OK;
        r.src_part = '0;
        r.src_row  = '0;
        r.last     = 0;
        for (int c = 0; c < 4; c++)
            r.keys[c] = '0;
        case (op)
            OP_LOAD:
            begin
                if (fill[part] >= NROWS)
                    r.status = ST_DROP;
                else
                begin
                    for (int c = 0; c < 4; c++)
                        row_store[c][part*NROWS + fill[part]] = k[c];
                    fill[part]++;
                end
            end
            OP_PULL:
            begin
                best = -1;
                best_addr = 0;
                for (int p = 0; p < NPART; p++)
                begin
                    if (head[p] < fill[p])
                    begin
                        addr = p*NROWS + head[p];
                        if (best < 0 || row_below(addr, best_addr))
                        begin
                            best = p;
                            best_addr = addr;
                        end
                    end
                end
                if (best < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.src_part = best[2:0];
                    r.src_row  = head[best][7:0];
                    for (int c = 0; c < used_cols(); c++)
                    begin
                        t = col_types[2*c +: 2];
                        r.keys[c] = (t == CT_INT32 || t == CT_FP32) ?
                                    {32'd0, row_store[c][best_addr][31:0]} :
                                    row_store[c][best_addr];
                    end
                    head[best]++;
                    r.last = 1;
                    for (int p = 0; p < NPART; p++)
                        if (head[p] < fill[p])
                            r.last = 0;
                end
            end
            OP_CLEAR:
            begin
                for (int p = 0; p < NPART; p++)
                begin
                    fill[p] = 0;
                    head[p] = 0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign waiting = pending_rows.size();

    always @(posedge clk or negedge rst_n)
    begin
        merge_row_t       want;
        logic [63:0]      k [4];
        logic [63:0]      got [4];
        if (!rst_n)
        begin
            for (int p = 0; p < NPART; p++)
            begin
                fill[p] = 0;
                head[p] = 0;
            end
            key_count = 3'd1;
            col_types = '0;
            fails     = 0;
            checked   = 0;
            pending_rows.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index_t'(cfg_index) == CFG_KEY_COUNT)
                    key_count = cfg_data[2:0];
                else
                    col_types = cfg_data;
            end
            if (in_mon.valid && in_mon.ready)
            begin
                k[0] = in_mon.key_0;
                k[1] = in_mon.key_1;
                k[2] = in_mon.key_2;
                k[3] = in_mon.key_3;
                pending_rows.push_back(merge_step(op_t'(in_mon.operation),
                                                  in_mon.partition, k));
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got[0] = out_mon.out_key_0;
                got[1] = out_mon.out_key_1;
                got[2] = out_mon.out_key_2;
                got[3] = out_mon.out_key_3;
                checked++;
                if (pending_rows.size() == 0)
                begin
                    $display("%0t: unexpected word, status %0d", $time, out_mon.status);
                    fails++;
                end
                else
                begin
                    want = pending_rows.pop_front();
                    if (out_mon.status !== want.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, want.status,
                                 out_mon.status);
                        fails++;
                    end
                    if (out_mon.source_partition !== want.src_part)
                    begin
                        $display("%0t: source_partition exp %0d got %0d", $time,
                                 want.src_part, out_mon.source_partition);
                        fails++;
                    end
                    if (out_mon.source_row !== want.src_row)
                    begin
                        $display("%0t: source_row exp %0d got %0d", $time,
                                 want.src_row, out_mon.source_row);
                        fails++;
                    end
                    for (int c = 0; c < 4; c++)
                        if (got[c] !== want.keys[c])
                        begin
                            $display("%0t: out_key_%0d exp %h got %h", $time, c,
                                     want.keys[c], got[c]);
                            fails++;
                        end
                    if (out_mon.last !== want.last)
                    begin
                        $display("%0t: last exp %0d got %0d", $time, want.last,
                                 out_mon.last);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

>>> test/testbench.sv
module testbench;
    import mkm_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    int         fails;
    int         waiting;
    int         checked;
    int         words_sent;
    bit         quiet;
    bit         hold_req;

    mkm_in_if  in_ch ();
    mkm_out_if out_ch ();

    multi_key_k_way_merge_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    merge_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .fails     (fails),
        .waiting   (waiting),
        .checked   (checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #8000000;
        $display("multi_key_k_way_merge_core test failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h0000_0000_8000_0000;
            3: return '1;
            4: return 64'h7fff_ffff_ffff_ffff;
            5: return 64'h0000_0000_7fff_ffff;
            6: return 64'($urandom_range(0, 3));
            7: return {$urandom_range(0, 1) ? 32'hffff_ffff : 32'd0,
                       32'($urandom_range(0, 2)) << 30};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input op_t op, input logic [2:0] part, input logic [63:0] k0,
                             input logic [63:0] k1, input logic [63:0] k2,
                             input logic [63:0] k3);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.operation = op;
        in_ch.partition = part;
        in_ch.key_0     = k0;
        in_ch.key_1     = k1;
        in_ch.key_2     = k2;
        in_ch.key_3     = k3;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_op(input op_t op, input logic [2:0] part);
        send_word(op, part, pick_key(), pick_key(), pick_key(), pick_key());
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_reg(input cfg_index_t idx, input logic [7:0] val);
        drain();
        cfg_index = idx;
        cfg_data  = val;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        int loads;
        int n;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = 1'b0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.partition = '0;
        in_ch.key_0     = '0;
        in_ch.key_1     = '0;
        in_ch.key_2     = '0;
        in_ch.key_3     = '0;
        quiet           = 0;
        hold_req        = 0;
        words_sent      = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, every operation, ties, empty pulls
        send_op(OP_PULL, 3'd0);
        send_word(OP_LOAD, 3'd7, '1, '1, '1, '1);
        send_word(OP_LOAD, 3'd0, '0, '0, '0, '0);
        send_word(OP_LOAD, 3'd3, 64'h8000_0000_0000_0000, '0, '1, '0);
        send_word(OP_LOAD, 3'd5, 64'h7fff_ffff_ffff_ffff, '1, '0, '1);
        send_word(OP_LOAD, 3'd1, '0, '1, '0, '1);
        send_op(OP_NONE, 3'd2);
        repeat (6) send_op(OP_PULL, 3'd0);
        send_word(OP_LOAD, 3'd2, 64'h8000_0000, 64'h8000_0000_0000_0000, '0, '0);
        send_word(OP_LOAD, 3'd4, '0, '0, '0, '0);
        set_reg(CFG_KEY_COUNT, 8'd4);
        set_reg(CFG_TYPES, 8'he4);
        send_word(OP_LOAD, 3'd6, 64'h8000_0000, 64'h8000_0000_0000_0000, '0, '0);
        send_op(OP_PULL, 3'd0);
        send_op(OP_CLEAR, 3'd0);
        send_op(OP_PULL, 3'd0);
        set_reg(CFG_TYPES, 8'hff);
        send_word(OP_LOAD, 3'd0, 64'h8000_0000_0000_0000, '0, '0, '0);
        send_word(OP_LOAD, 3'd1, '0, '0, '0, '0);
        send_word(OP_LOAD, 3'd2, 64'hfff0_0000_0000_0000, '0, '0, '0);
        repeat (4) send_op(OP_PULL, 3'd0);

        // fill one partition past its end, with the receiver held off
        set_reg(CFG_KEY_COUNT, 8'd0);
        set_reg(CFG_TYPES, 8'h00);
        hold_req = 1;
        for (int i = 0; i < 258; i++)
            send_word(OP_LOAD, 3'd5, 64'(i), pick_key(), pick_key(), pick_key());
        for (int i = 0; i < 257; i++)
            send_op(OP_PULL, 3'd0);

        // random phases of loads, interleaved pulls and noise, then drain
        while (words_sent < 1150)
        begin
            if (words_sent > 1000)
                quiet = 1;
            set_reg(CFG_KEY_COUNT, 8'($urandom_range(0, 7)));
            set_reg(CFG_TYPES, 8'($urandom_range(0, 255)));
            send_op(OP_CLEAR, 3'($urandom));
            loads = 0;
            n = $urandom_range(4, 30);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: send_op(OP_PULL, 3'($urandom));
                    2: send_op($urandom_range(0, 1) ? OP_NONE : OP_CLEAR, 3'($urandom));
                    default:
                    begin
                        send_op(OP_LOAD, 3'($urandom));
                        loads++;
                    end
                endcase
            end
            for (int i = 0; i <= loads; i++)
                send_op(OP_PULL, 3'($urandom));
        end
        set_reg(CFG_KEY_COUNT, 8'd7);
        set_reg(CFG_TYPES, 8'hff);
        drain();

        $display("%0d words sent, %0d results checked over key counts 0..7,",
                 words_sent, checked);
        $display("all column types, full partition, empty pulls and clears");
        if (fails == 0)
            $display("multi_key_k_way_merge_core test passed");
        else
            $display("multi_key_k_way_merge_core test failed");
        $finish;
    end
endmodule
